>>> rtl/sit2d_pkg.sv
`timescale 1ns / 1ps
// sit2d_pkg: widths, register codes and stage records shared by the segment intersection test
// depends on nothing; imported by every module of the block

package sit2d_pkg;

  localparam int CoordW    = 16;
  localparam int TolW      = 16;

  localparam int DiffW     = CoordW + 1;            // difference of two coordinates
  localparam int ProdW     = 2 * DiffW;             // signed product of two differences
  localparam int AreaW     = ProdW + 1;             // cross or dot of two difference vectors
  localparam int SqW       = 2 * CoordW + 1;        // square of one difference, unsigned
  localparam int NormW     = SqW + 1;               // |b-a|^2
  localparam int SumW      = NormW + 1;             // |b-a|^2 + |d-c|^2
  localparam int Tol2W     = 2 * TolW;
  localparam int LimW      = Tol2W + SumW;          // tolerance^2 * S
  localparam int LimLoW    = LimW / 2;
  localparam int LimHiW    = LimW - LimLoW;
  localparam int QuadW     = 2 * LimW;              // (tolerance^2 * S)^2
  localparam int SideShift = 2 * Tol2W + 2;
  localparam int ColShift  = Tol2W + 1;
  localparam int ProjShift = TolW;
  localparam int SideW     = 2 * AreaW + SideShift;
  localparam int ColW      = AreaW + ColShift;
  localparam int HiLimW    = NormW + TolW + 1;
  localparam int LoLimW    = NormW + TolW;
  localparam int ProjW     = AreaW + ProjShift + 1;
  localparam int Latency   = 7;

  typedef enum logic [0:0] {
    CFG_TRANSVERSAL = 1'b0,
    CFG_TOLERANCE   = 1'b1
  } cfg_idx_e;

  // areas, norms and projections after the third stage
  typedef struct packed {
    logic                     valid;
    logic signed [AreaW-1:0]  a1;
    logic signed [AreaW-1:0]  a2;
    logic signed [AreaW-1:0]  a3;
    logic        [NormW-1:0]  n;
    logic        [SumW-1:0]   s;
    logic signed [AreaW-1:0]  pc;
    logic signed [AreaW-1:0]  pd;
    logic        [Tol2W-1:0]  t2;
  } area_t;

  // side products, squared limit partials and flags after the fifth stage
  typedef struct packed {
    logic                      valid;
    logic signed [2*AreaW-1:0] p1;
    logic signed [2*AreaW-1:0] p2;
    logic [2*LimHiW-1:0]       hh;
    logic [LimW-1:0]           hl;
    logic [2*LimLoW-1:0]       ll;
    logic                      colin;
    logic                      proj_ok;
    logic                      n_zero;
    logic                      cross_hit;
  } bound_t;

  function automatic logic signed [DiffW-1:0] diff(logic signed [CoordW-1:0] p,
                                                   logic signed [CoordW-1:0] q);
    diff = DiffW'(p) - DiffW'(q);
  endfunction

  function automatic logic signed [ProdW-1:0] smul(logic signed [DiffW-1:0] x,
                                                   logic signed [DiffW-1:0] y);
    smul = ProdW'(x) * ProdW'(y);
  endfunction

endpackage

>>> rtl/sit2d_area.sv
`timescale 1ns / 1ps
// sit2d_area: stages one to three, coordinate differences, products and their sums
// depends on sit2d_pkg

module sit2d_area (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_a_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_a_y_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_b_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_b_y_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_c_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_c_y_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_d_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_d_y_i,
  input  logic        [sit2d_pkg::TolW-1:0]    tolerance_i,
  output sit2d_pkg::area_t                     area_o
);
  import sit2d_pkg::*;

  logic v1_q, v2_q, v3_q;

  // stage 1: difference vectors
  logic signed [DiffW-1:0] adx_q, ady_q, bdx_q, bdy_q, acx_q, acy_q, bcx_q, bcy_q;
  logic signed [DiffW-1:0] cax_q, cay_q, dax_q, day_q, bax_q, bay_q, dcx_q, dcy_q;

  // stage 2: products
  logic signed [ProdW-1:0] a1p_q, a1m_q, a2p_q, a2m_q, a3p_q, a3m_q;
  logic signed [ProdW-1:0] nxx_q, nyy_q, mxx_q, myy_q, pcx_q, pcy_q, pdx_q, pdy_q;
  logic        [Tol2W-1:0] t2_q;

  // stage 3: sums
  logic signed [AreaW-1:0] a1_q, a2_q, a3_q, pc_q, pd_q;
  logic        [NormW-1:0] n_d, n_q;
  logic        [SumW-1:0]  s_q;
  logic        [Tol2W-1:0] t2s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q <= diff(point_a_x_i, point_d_x_i);
    ady_q <= diff(point_a_y_i, point_d_y_i);
    bdx_q <= diff(point_b_x_i, point_d_x_i);
    bdy_q <= diff(point_b_y_i, point_d_y_i);
    acx_q <= diff(point_a_x_i, point_c_x_i);
    acy_q <= diff(point_a_y_i, point_c_y_i);
    bcx_q <= diff(point_b_x_i, point_c_x_i);
    bcy_q <= diff(point_b_y_i, point_c_y_i);
    cax_q <= diff(point_c_x_i, point_a_x_i);
    cay_q <= diff(point_c_y_i, point_a_y_i);
    dax_q <= diff(point_d_x_i, point_a_x_i);
    day_q <= diff(point_d_y_i, point_a_y_i);
    bax_q <= diff(point_b_x_i, point_a_x_i);
    bay_q <= diff(point_b_y_i, point_a_y_i);
    dcx_q <= diff(point_d_x_i, point_c_x_i);
    dcy_q <= diff(point_d_y_i, point_c_y_i);
  end

  always_ff @(posedge clk_i) begin
    a1p_q <= smul(adx_q, bdy_q);
    a1m_q <= smul(ady_q, bdx_q);
    a2p_q <= smul(acx_q, bcy_q);
    a2m_q <= smul(acy_q, bcx_q);
    a3p_q <= smul(cax_q, day_q);
    a3m_q <= smul(cay_q, dax_q);
    nxx_q <= smul(bax_q, bax_q);
    nyy_q <= smul(bay_q, bay_q);
    mxx_q <= smul(dcx_q, dcx_q);
    myy_q <= smul(dcy_q, dcy_q);
    pcx_q <= smul(cax_q, bax_q);
    pcy_q <= smul(cay_q, bay_q);
    pdx_q <= smul(dax_q, bax_q);
    pdy_q <= smul(day_q, bay_q);
    t2_q  <= Tol2W'(tolerance_i) * Tol2W'(tolerance_i);
  end

  // squares are never negative, so the low bits carry the whole value
  assign n_d = NormW'(nxx_q[SqW-1:0]) + NormW'(nyy_q[SqW-1:0]);

  always_ff @(posedge clk_i) begin
    a1_q  <= AreaW'(a1p_q) - AreaW'(a1m_q);
    a2_q  <= AreaW'(a2p_q) - AreaW'(a2m_q);
    a3_q  <= AreaW'(a3p_q) - AreaW'(a3m_q);
    pc_q  <= AreaW'(pcx_q) + AreaW'(pcy_q);
    pd_q  <= AreaW'(pdx_q) + AreaW'(pdy_q);
    n_q   <= n_d;
    s_q   <= SumW'(n_d) + SumW'(mxx_q[SqW-1:0]) + SumW'(myy_q[SqW-1:0]);
    t2s_q <= t2_q;
  end

  assign area_o = '{valid: v3_q, a1: a1_q, a2: a2_q, a3: a3_q, n: n_q, s: s_q,
                    pc: pc_q, pd: pd_q, t2: t2s_q};

endmodule

>>> rtl/sit2d_limit.sv
`timescale 1ns / 1ps
// sit2d_limit: stages four and five, tolerance limits, side products and collinear checks
// depends on sit2d_pkg

module sit2d_limit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sit2d_pkg::area_t                  area_i,
  input  logic [sit2d_pkg::TolW-1:0]        tolerance_i,
  output sit2d_pkg::bound_t                 bound_o
);
  import sit2d_pkg::*;

  // stage 4
  logic                     v4_q, v5_q;
  logic signed [AreaW+1:0]  a4_wide;
  logic signed [AreaW-1:0]  a4_d;
  logic                     swap;
  logic signed [AreaW-1:0]  a1_q, a2_q, a3_q, a4_q, pmin_q, pmax_q;
  logic        [AreaW-1:0]  mag1_q, mag2_q;
  logic        [LimW-1:0]   lim_q;
  logic        [HiLimW-1:0] hi_lim_q;
  logic        [LoLimW-1:0] lo_lim_q;
  logic                     n_zero_q;

  // stage 5
  logic        [LimLoW-1:0] lim_lo;
  logic        [LimHiW-1:0] lim_hi;
  logic signed [ProjW-1:0]  pmin_s, pmax_s, hi_s, lo_neg;
  logic                     colin_d, proj_ok_d, cross_d;
  logic signed [2*AreaW-1:0] p1_q, p2_q;
  logic [2*LimHiW-1:0]      hh_q;
  logic [LimW-1:0]          hl_q;
  logic [2*LimLoW-1:0]      ll_q;
  logic                     colin_q, proj_ok_q, n_zero5_q, cross_q;

  // the fourth area is itself a cross product, so it always fits the area width
  assign a4_wide = (AreaW+2)'(area_i.a3) + (AreaW+2)'(area_i.a2) - (AreaW+2)'(area_i.a1);
  assign a4_d    = a4_wide[AreaW-1:0];
  assign swap    = area_i.pc > area_i.pd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= area_i.valid;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q     <= area_i.a1;
    a2_q     <= area_i.a2;
    a3_q     <= area_i.a3;
    a4_q     <= a4_d;
    mag1_q   <= area_i.a1[AreaW-1] ? AreaW'(-area_i.a1) : AreaW'(area_i.a1);
    mag2_q   <= area_i.a2[AreaW-1] ? AreaW'(-area_i.a2) : AreaW'(area_i.a2);
    lim_q    <= LimW'(area_i.t2) * LimW'(area_i.s);
    hi_lim_q <= HiLimW'(area_i.n) * HiLimW'({1'b1, tolerance_i});
    lo_lim_q <= LoLimW'(area_i.n) * LoLimW'(tolerance_i);
    pmin_q   <= swap ? area_i.pd : area_i.pc;
    pmax_q   <= swap ? area_i.pc : area_i.pd;
    n_zero_q <= area_i.n == '0;
  end

  assign lim_lo = lim_q[LimLoW-1:0];
  assign lim_hi = lim_q[LimW-1:LimLoW];

  assign pmin_s = {pmin_q[AreaW-1], pmin_q, {ProjShift{1'b0}}};
  assign pmax_s = {pmax_q[AreaW-1], pmax_q, {ProjShift{1'b0}}};
  assign hi_s   = {1'b0, hi_lim_q};
  assign lo_neg = -{2'b00, lo_lim_q};

  always_comb begin
    colin_d   = ({mag1_q, {ColShift{1'b0}}} <= ColW'(lim_q)) &&
                ({mag2_q, {ColShift{1'b0}}} <= ColW'(lim_q));
    proj_ok_d = !((pmin_s > hi_s) || (pmax_s < lo_neg));
    // strict crossing: both pairs nonzero with opposite signs
    cross_d   = (a1_q != '0) && (a2_q != '0) && (a1_q[AreaW-1] != a2_q[AreaW-1]) &&
                (a3_q != '0) && (a4_q != '0) && (a3_q[AreaW-1] != a4_q[AreaW-1]);
  end

  always_ff @(posedge clk_i) begin
    p1_q      <= (2*AreaW)'(a1_q) * (2*AreaW)'(a2_q);
    p2_q      <= (2*AreaW)'(a3_q) * (2*AreaW)'(a4_q);
    hh_q      <= (2*LimHiW)'(lim_hi) * (2*LimHiW)'(lim_hi);
    hl_q      <= LimW'(lim_hi) * LimW'(lim_lo);
    ll_q      <= (2*LimLoW)'(lim_lo) * (2*LimLoW)'(lim_lo);
    colin_q   <= colin_d;
    proj_ok_q <= proj_ok_d;
    n_zero5_q <= n_zero_q;
    cross_q   <= cross_d;
  end

  assign bound_o = '{valid: v5_q, p1: p1_q, p2: p2_q, hh: hh_q, hl: hl_q, ll: ll_q,
                     colin: colin_q, proj_ok: proj_ok_q, n_zero: n_zero5_q,
                     cross_hit: cross_q};

`ifndef SYNTHESIS
  a4_fits_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    area_i.valid |-> (a4_wide == (AreaW+2)'(a4_d)))
    else $error("fourth area does not fit its width");

  proj_order_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (pmin_q <= pmax_q))
    else $error("projection bounds out of order");
`endif

endmodule

>>> rtl/sit2d_decide.sv
`timescale 1ns / 1ps
// sit2d_decide: stages six and seven, squared limit sum, side tests and the result register
// depends on sit2d_pkg

module sit2d_decide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sit2d_pkg::bound_t bound_i,
  input  logic              transversal_i,
  output logic              done_o,
  output logic              intersects_o
);
  import sit2d_pkg::*;

  logic                      v6_q, done_q;
  logic [QuadW-1:0]          quad_q;
  logic signed [2*AreaW-1:0] p1_q, p2_q;
  logic                      colin_q, proj_ok_q, n_zero_q, cross_q;
  logic                      side1, side2, hit_d, intersects_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v6_q   <= bound_i.valid;
      done_q <= v6_q;
    end
  end

  // (hi*2^k + lo)^2 = hh*2^2k + 2*hl*2^k + ll
  always_ff @(posedge clk_i) begin
    quad_q    <= (QuadW'(bound_i.hh) << (2*LimLoW)) + (QuadW'(bound_i.hl) << (LimLoW+1)) +
                 QuadW'(bound_i.ll);
    p1_q      <= bound_i.p1;
    p2_q      <= bound_i.p2;
    colin_q   <= bound_i.colin;
    proj_ok_q <= bound_i.proj_ok;
    n_zero_q  <= bound_i.n_zero;
    cross_q   <= bound_i.cross_hit;
  end

  always_comb begin
    side1 = p1_q[2*AreaW-1] || (p1_q == '0) ||
            ({p1_q, {SideShift{1'b0}}} <= SideW'(quad_q));
    side2 = p2_q[2*AreaW-1] || (p2_q == '0) ||
            ({p2_q, {SideShift{1'b0}}} <= SideW'(quad_q));
    if (transversal_i) begin
      hit_d = cross_q;
    end else begin
      // near-collinear pairs fall back to the projection overlap
      hit_d = side1 && side2 && (!colin_q || n_zero_q || proj_ok_q);
    end
  end

  always_ff @(posedge clk_i) begin
    intersects_q <= hit_d;
  end

  assign done_o       = done_q;
  assign intersects_o = intersects_q;

endmodule

>>> rtl/segment_intersection_test_2d_top.sv
`timescale 1ns / 1ps
// segment_intersection_test_2d_top: configuration registers and the seven-stage test pipeline
// depends on sit2d_pkg, sit2d_area, sit2d_limit, sit2d_decide
//
// usage
// - a request (two segments ab and cd, signed coordinates) is taken at every rising edge
//   with start_i high; busy_o stays low, the pipeline takes one request every cycle
// - the answer appears on intersects_o with done_o high for exactly one cycle, once the
//   request has passed the register stages listed below; answers come back in request order
// - throughput is one request per cycle; there are seven register stages, in order:
//   differences, products, sums, limits, side products, squared limit sum, decision
// - the receiver cannot hold results off; none is needed, results never wait
// - registers: index 0 transversal_only (bit 0), index 1 tolerance (Q0.16); write them
//   with cfg_we_i only while no request is in flight
// - reset clears both registers and all stage valid bits, so no stale answer appears

module segment_intersection_test_2d_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_a_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_a_y_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_b_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_b_y_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_c_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_c_y_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_d_x_i,
  input  logic signed [sit2d_pkg::CoordW-1:0]  point_d_y_i,
  output logic                                 done_o,
  output logic                                 intersects_o,
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_idx_i,
  input  logic [sit2d_pkg::TolW-1:0]           cfg_wdata_i
);
  import sit2d_pkg::*;

  logic              transversal_q, transversal_d;
  logic [TolW-1:0]   tolerance_q, tolerance_d;
  logic              req;
  area_t             area;
  bound_t            bound;

  always_comb begin
    transversal_d = transversal_q;
    tolerance_d   = tolerance_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TRANSVERSAL: transversal_d = cfg_wdata_i[0];
        CFG_TOLERANCE:   tolerance_d   = cfg_wdata_i;
        default:         transversal_d = transversal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transversal_q <= 1'b0;
      tolerance_q   <= '0;
    end else begin
      transversal_q <= transversal_d;
      tolerance_q   <= tolerance_d;
    end
  end

  // fully pipelined, so a request is never refused
  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  sit2d_area u_area (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .point_a_x_i (point_a_x_i),
    .point_a_y_i (point_a_y_i),
    .point_b_x_i (point_b_x_i),
    .point_b_y_i (point_b_y_i),
    .point_c_x_i (point_c_x_i),
    .point_c_y_i (point_c_y_i),
    .point_d_x_i (point_d_x_i),
    .point_d_y_i (point_d_y_i),
    .tolerance_i (tolerance_q),
    .area_o      (area)
  );

  sit2d_limit u_limit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .area_i      (area),
    .tolerance_i (tolerance_q),
    .bound_o     (bound)
  );

  sit2d_decide u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bound_i       (bound),
    .transversal_i (transversal_q),
    .done_o        (done_o),
    .intersects_o  (intersects_o)
  );

`ifndef SYNTHESIS
  req_to_done_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##Latency done_o)
    else $error("request produced no result after the pipeline latency");

  done_from_req_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req, Latency))
    else $error("result without a matching request");
`endif

endmodule
